FILE: design/quadratic_probe_map_insert_unit_assert.svh
// ----------------------------------------------------------------------------
// quadratic probe map insert assertion macros
// clocked assertion helpers used by the insert unit
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_PROBE_MAP_INSERT_UNIT_ASSERT_SVH
`define QUADRATIC_PROBE_MAP_INSERT_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define QPMI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define QPMI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define QPMI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/qpmi_pkg.sv
// ----------------------------------------------------------------------------
// qpmi_pkg
// shared types and constants of the quadratic probe map insert unit
// ----------------------------------------------------------------------------
package qpmi_pkg;

  localparam int unsigned DefTableSlots = 1024;
  localparam int unsigned KeyW          = 32;
  localparam int unsigned PageW         = 32;
  localparam int unsigned CntOutW       = 11;

  localparam logic [CntOutW-1:0] CapReset = 11'd512;
  localparam logic [CntOutW-1:0] ProbeSat = 11'h7FF;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // status codes
  localparam logic [1:0] ST_NEW     = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  // one slot of the table
  typedef struct packed {
    logic             used;
    logic [KeyW-1:0]  key;
    logic [PageW-1:0] page;
  } slot_t;

  // sequencer commands to the probe generator
  typedef struct packed {
    logic load;
    logic advance;
  } probe_cmd_t;

endpackage

FILE: design/qpmi_slot_mem.sv
// ----------------------------------------------------------------------------
// qpmi_slot_mem
// single-port slot memory with registered read data
// ----------------------------------------------------------------------------
module qpmi_slot_mem #(
  parameter int unsigned Slots = 1024,
  parameter int unsigned DataW = 65,
  localparam int unsigned AddrW = $clog2(Slots)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Slots];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/qpmi_probe_gen.sv
// ----------------------------------------------------------------------------
// qpmi_probe_gen
// quadratic probe address generator, one probe step per advance
// ----------------------------------------------------------------------------
module qpmi_probe_gen #(
  parameter int unsigned TableSlots = 1024,
  localparam int unsigned SlotAw = $clog2(TableSlots),
  localparam int unsigned CntW = SlotAw + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qpmi_pkg::probe_cmd_t  cmd_i,
  input  logic [SlotAw-1:0]     hash_i,
  output logic [SlotAw-1:0]     idx_o,
  output logic [CntW-1:0]       probes_o,
  output logic                  exhausted_o
);
  import qpmi_pkg::*;

  // offset i*i+i grows by 2*(i+1) from one probe to the next
  logic [SlotAw-1:0] idx_q, idx_d;
  logic [SlotAw-1:0] step_q, step_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    idx_d  = idx_q;
    step_d = step_q;
    cnt_d  = cnt_q;
    if (cmd_i.load) begin
      idx_d  = hash_i;
      step_d = SlotAw'(2);
      cnt_d  = CntW'(1);
    end else if (cmd_i.advance) begin
      idx_d  = idx_q + step_q;
      step_d = step_q + SlotAw'(2);
      cnt_d  = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      step_q <= '0;
      cnt_q  <= '0;
    end else begin
      idx_q  <= idx_d;
      step_q <= step_d;
      cnt_q  <= cnt_d;
    end
  end

  assign idx_o       = idx_q;
  assign probes_o    = cnt_q;
  assign exhausted_o = (cnt_q == CntW'(TableSlots));

endmodule

FILE: design/quadratic_probe_map_insert_unit.sv
// ----------------------------------------------------------------------------
// quadratic_probe_map_insert_unit
// open-addressing page map with quadratic probing, one request at a time
// ----------------------------------------------------------------------------
// insert: each probe is a memory read, then a compare and write on the single
//   slot port; the result word follows the last probe
// insert refused by capacity goes straight to the result; clear sweeps every slot first
// requests: one in flight; next accepted once the result is queued
// reset: async active low; a sweep over all TABLE_SLOTS slots empties the table,
//   no request is taken meanwhile (capacity writes are)
// ----------------------------------------------------------------------------
`include "quadratic_probe_map_insert_unit_assert.svh"

module quadratic_probe_map_insert_unit #(
  // number of slots, a power of two; the hash is the key's low bits
  parameter int unsigned TABLE_SLOTS = qpmi_pkg::DefTableSlots
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // capacity register
  input  logic                          cfg_we_i,
  input  logic [qpmi_pkg::CntOutW-1:0]  cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [qpmi_pkg::KeyW-1:0]     logical_page_i,
  input  logic [qpmi_pkg::PageW-1:0]    physical_page_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [qpmi_pkg::PageW-1:0]    old_page_o,
  output logic [qpmi_pkg::CntOutW-1:0]  probe_count_o,
  output logic [qpmi_pkg::CntOutW-1:0]  entry_count_o,
  output logic [qpmi_pkg::CntOutW-1:0]  longest_probe_o,
  output logic [qpmi_pkg::KeyW-1:0]     lowest_key_o,
  output logic [qpmi_pkg::KeyW-1:0]     highest_key_o
);
  import qpmi_pkg::*;

  localparam int unsigned SlotAw = $clog2(TABLE_SLOTS);
  localparam int unsigned CntW   = SlotAw + 1;
  localparam int unsigned SlotW  = $bits(slot_t);

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLR   = 5'b00010,
    S_READ  = 5'b00100,
    S_CHECK = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // capacity register
  logic [CntOutW-1:0] cap_q, cap_d;

  // table statistics
  logic [CntW-1:0]    used_q, used_d;
  logic [CntOutW-1:0] max_probe_q, max_probe_d;
  logic [KeyW-1:0]    min_key_q, min_key_d;
  logic [KeyW-1:0]    max_key_q, max_key_d;

  // clear sweep; report marks a sweep started by a clear word, not by reset
  logic [SlotAw-1:0] clr_addr_q, clr_addr_d;
  logic              report_q, report_d;

  // latched request and pending result fields
  logic [KeyW-1:0]    key_q, key_d;
  logic [PageW-1:0]   page_q, page_d;
  logic [1:0]         res_status_q, res_status_d;
  logic [PageW-1:0]   res_old_q, res_old_d;
  logic [CntOutW-1:0] res_probes_q, res_probes_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  logic [1:0]         status_q;
  logic [PageW-1:0]   old_page_q;
  logic [CntOutW-1:0] probe_count_q, entry_count_q, longest_probe_q;
  logic [KeyW-1:0]    lowest_key_q, highest_key_q;

  // slot memory and probe generator
  logic              mem_we;
  logic [SlotAw-1:0] mem_addr;
  slot_t             mem_wdata;
  slot_t             mem_rdata;
  logic [SlotW-1:0]  mem_rdata_raw;

  probe_cmd_t        pcmd;
  logic [SlotAw-1:0] probe_idx;
  logic [CntW-1:0]   probes;
  logic              probe_exhausted;

  logic in_acc;
  logic key_hit;

  qpmi_slot_mem #(
    .Slots (TABLE_SLOTS),
    .DataW (SlotW)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata_raw)
  );

  assign mem_rdata = mem_rdata_raw;

  qpmi_probe_gen #(
    .TableSlots (TABLE_SLOTS)
  ) u_probe_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pcmd),
    .hash_i      (key_d[SlotAw-1:0]),
    .idx_o       (probe_idx),
    .probes_o    (probes),
    .exhausted_o (probe_exhausted)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign key_hit    = mem_rdata.used && (mem_rdata.key == key_q);

  always_comb begin
    state_d      = state_q;
    cap_d        = cfg_we_i ? cfg_wdata_i : cap_q;
    used_d       = used_q;
    max_probe_d  = max_probe_q;
    min_key_d    = min_key_q;
    max_key_d    = max_key_q;
    clr_addr_d   = clr_addr_q;
    report_d     = report_q;
    key_d        = key_q;
    page_d       = page_q;
    res_status_d = res_status_q;
    res_old_d    = res_old_q;
    res_probes_d = res_probes_q;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = probe_idx;
    mem_wdata    = '{used: 1'b1, key: key_q, page: page_q};
    pcmd         = '{load: 1'b0, advance: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d        = logical_page_i;
          page_d       = physical_page_i;
          res_old_d    = '0;
          res_probes_d = '0;
          if (req_type_i == REQ_CLEAR) begin
            // stats drop at once, slots empty over the sweep
            used_d       = '0;
            max_probe_d  = '0;
            min_key_d    = '1;
            max_key_d    = '0;
            clr_addr_d   = '0;
            report_d     = 1'b1;
            res_status_d = ST_CLEARED;
            state_d      = S_CLR;
          end else if (32'(used_q) < 32'(cap_q)) begin
            pcmd.load = 1'b1;
            state_d   = S_READ;
          end else begin
            res_status_d = ST_FULL;
            state_d      = S_FIN;
          end
        end
      end

      S_CLR: begin
        mem_we     = 1'b1;
        mem_addr   = clr_addr_q;
        mem_wdata  = '{used: 1'b0, key: '0, page: '0};
        clr_addr_d = clr_addr_q + SlotAw'(1);
        if (clr_addr_q == SlotAw'(TABLE_SLOTS - 1)) begin
          state_d  = report_q ? S_FIN : S_IDLE;
          report_d = 1'b0;
        end
      end

      // slot address presented, data back next cycle
      S_READ: begin
        state_d = S_CHECK;
      end

      S_CHECK: begin
        res_probes_d = CntOutW'(probes);
        if (!mem_rdata.used) begin
          // empty slot takes the pair
          mem_we       = 1'b1;
          used_d       = used_q + CntW'(1);
          if (32'(probes) > 32'(max_probe_q)) begin
            max_probe_d = (32'(probes) > 32'(ProbeSat)) ? ProbeSat : CntOutW'(probes);
          end
          if (key_q < min_key_q) min_key_d = key_q;
          if (key_q > max_key_q) max_key_d = key_q;
          res_status_d = ST_NEW;
          state_d      = S_FIN;
        end else if (key_hit) begin
          // same key: swap in the new page, hand back the old one
          mem_we       = 1'b1;
          res_old_d    = mem_rdata.page;
          if (key_q < min_key_q) min_key_d = key_q;
          if (key_q > max_key_q) max_key_d = key_q;
          res_status_d = ST_UPDATED;
          state_d      = S_FIN;
        end else if (probe_exhausted) begin
          res_status_d = ST_FULL;
          state_d      = S_FIN;
        end else begin
          pcmd.advance = 1'b1;
          state_d      = S_READ;
        end
      end

      // wait for the output register to free up
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cap_q       <= CapReset;
      used_q      <= '0;
      max_probe_q <= '0;
      min_key_q   <= '1;
      max_key_q   <= '0;
      clr_addr_q  <= '0;
      report_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      used_q      <= used_d;
      max_probe_q <= max_probe_d;
      min_key_q   <= min_key_d;
      max_key_q   <= max_key_d;
      clr_addr_q  <= clr_addr_d;
      report_q    <= report_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    page_q       <= page_d;
    res_status_q <= res_status_d;
    res_old_q    <= res_old_d;
    res_probes_q <= res_probes_d;
    if (out_load) begin
      status_q        <= res_status_q;
      old_page_q      <= res_old_q;
      probe_count_q   <= res_probes_q;
      entry_count_q   <= CntOutW'(used_q);
      longest_probe_q <= max_probe_q;
      lowest_key_q    <= min_key_q;
      highest_key_q   <= max_key_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign old_page_o      = old_page_q;
  assign probe_count_o   = probe_count_q;
  assign entry_count_o   = entry_count_q;
  assign longest_probe_o = longest_probe_q;
  assign lowest_key_o    = lowest_key_q;
  assign highest_key_o   = highest_key_q;

  // checks
  `QPMI_ASSERT(a_used_bound, 32'(used_q) <= 32'(TABLE_SLOTS), "entry count above table size")
  `QPMI_ASSERT_IMP(a_key_order, used_q != '0, min_key_q <= max_key_q, "key range inverted")
  `QPMI_ASSERT_IMP(a_empty_run, used_q == '0, max_probe_q == '0, "probe run without entries")
  `QPMI_ASSERT_IMP(a_mem_write, mem_we, (state_q == S_CHECK) || (state_q == S_CLR), "stray slot write")
  `QPMI_ASSERT_NXT(a_one_word, in_acc, !in_ready_o, "second word taken while busy")

endmodule
